/* sv/mlfq_pkg.sv */
// Shared types and constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

  // Field widths of the transfer payloads, the configuration register and the slice counters
  localparam int OP_W      = 2;
  localparam int TASK_ID_W = 5;
  localparam int LEVEL_W   = 2;
  localparam int STATUS_W  = 2;
  localparam int QUANTUM_W = 8;
  localparam int SLICE_W   = 11;

  // Largest slice count a task can hold
  localparam logic [SLICE_W-1:0] SLICE_MAX = '1;

  // Quantum granted at the top level after reset
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd10;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_SCHEDULE = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_IDLE = 2'd1,
    STATUS_BAD  = 2'd2
  } status_t;

endpackage

/* sv/mlfq_if.sv */
// Request and result channel interfaces of the scheduler.
interface mlfq_in_if;
  logic                           valid;
  logic                           ready;
  logic [mlfq_pkg::OP_W-1:0]      operation;
  logic [mlfq_pkg::TASK_ID_W-1:0] task_id;
  logic [mlfq_pkg::LEVEL_W-1:0]   level;
  logic                           current_ready;

  modport source (output valid, operation, task_id, level, current_ready, input ready);
  modport sink   (input valid, operation, task_id, level, current_ready, output ready);
endinterface

interface mlfq_out_if;
  logic                           valid;
  logic                           ready;
  logic [mlfq_pkg::TASK_ID_W-1:0] running_task;
  logic                           switched;
  logic [mlfq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, running_task, switched, status, input ready);
  modport sink   (input valid, running_task, switched, status, output ready);
endinterface

/* sv/mlfq_task_scheduler.sv */
// Multilevel feedback queue scheduler: request register, one-pass update, result register.
// Throughput: one request per cycle while the result register is free or being drained;
// the whole queue update for a request is done by the logic between the request register
// and the result register, against flop-based tables.
// Reset (synchronous, rst_n low): all levels empty, no running task, slices and levels cleared,
// base quantum back to 10. Link tables are not reset; they are written on enqueue and unlink.
module mlfq_task_scheduler #(
  parameter int NUM_LEVELS = 4,
  parameter int NUM_TASKS  = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mlfq_in_if.sink                          in_chan,
  mlfq_out_if.source                       out_chan,
  input  logic                             cfg_wr_en,
  input  logic [mlfq_pkg::QUANTUM_W-1:0]   cfg_wr_data
);

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int Q_W   = mlfq_pkg::SLICE_W + NUM_LEVELS;

  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [LVL_W-1:0]             lvl_t;
  typedef logic [mlfq_pkg::SLICE_W-1:0] slice_t;

  // Configuration
  logic [mlfq_pkg::QUANTUM_W-1:0] base_quantum_r;

  // Request register
  logic                              item_valid_r;
  mlfq_pkg::op_t                     op_r;
  logic [mlfq_pkg::TASK_ID_W-1:0]    id_r;
  logic [mlfq_pkg::LEVEL_W-1:0]      lvl_r;
  logic                              ready_r;

  // Result register
  logic                              out_valid_r;
  logic [mlfq_pkg::TASK_ID_W-1:0]    out_task_r;
  logic                              out_switched_r;
  mlfq_pkg::status_t                 out_status_r;

  // Scheduler state
  idx_t   head_r     [NUM_LEVELS];
  logic   nonempty_r [NUM_LEVELS];
  idx_t   next_r     [NUM_TASKS];
  idx_t   prev_r     [NUM_TASKS];
  lvl_t   tlevel_r   [NUM_TASKS];
  slice_t slices_r   [NUM_TASKS];
  logic   queued_r   [NUM_TASKS];
  idx_t   cur_task_r;
  logic   cur_valid_r;

  idx_t   head_nxt     [NUM_LEVELS];
  logic   nonempty_nxt [NUM_LEVELS];
  idx_t   next_nxt     [NUM_TASKS];
  idx_t   prev_nxt     [NUM_TASKS];
  lvl_t   tlevel_nxt   [NUM_TASKS];
  slice_t slices_nxt   [NUM_TASKS];
  logic   queued_nxt   [NUM_TASKS];
  idx_t   cur_task_nxt;
  logic   cur_valid_nxt;

  // Update working signals
  logic              advance;
  logic              commit;
  logic              id_ok;
  idx_t              id_idx;
  lvl_t              lvl_in;
  lvl_t              cur_lvl;
  logic              do_deq;
  idx_t              deq_task;
  lvl_t              deq_lvl;
  idx_t              deq_n;
  idx_t              deq_p;
  logic              do_enq;
  idx_t              enq_task;
  lvl_t              enq_lvl;
  idx_t              enq_h;
  idx_t              enq_tail;
  logic [Q_W-1:0]    quantum;
  logic              do_rotate;
  logic              found;
  idx_t              pick;
  logic              switched;
  mlfq_pkg::status_t status;

  // Advance when the result register is free or being drained
  assign advance = !out_valid_r || out_chan.ready;
  assign commit  = item_valid_r && advance;
  assign in_chan.ready = !item_valid_r || advance;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.running_task = out_task_r;
  assign out_chan.switched     = out_switched_r;
  assign out_chan.status       = out_status_r;

  // Decode the request fields
  always_comb begin
    id_ok   = int'(id_r) < NUM_TASKS;
    id_idx  = IDX_W'(id_r);
    lvl_in  = (int'(lvl_r) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1) : LVL_W'(lvl_r);
    cur_lvl = tlevel_r[cur_task_r];
  end

  // Decide which queue edits the request makes
  always_comb begin
    do_deq    = 1'b0;
    deq_task  = id_idx;
    do_enq    = 1'b0;
    enq_task  = id_idx;
    enq_lvl   = lvl_in;
    do_rotate = 1'b0;
    case (op_r)
      mlfq_pkg::OP_ADD: begin
        do_enq = id_ok && !queued_r[id_idx];
      end
      mlfq_pkg::OP_REMOVE: begin
        do_deq = id_ok && queued_r[id_idx];
      end
      mlfq_pkg::OP_SCHEDULE: begin
        if (cur_valid_r && ready_r && queued_r[cur_task_r]) begin
          if (slices_r[cur_task_r] != '0) begin
            do_rotate = 1'b1;
          end else begin
            // demote one level, saturating at the lowest
            do_deq   = 1'b1;
            deq_task = cur_task_r;
            do_enq   = 1'b1;
            enq_task = cur_task_r;
            enq_lvl  = (cur_lvl == LVL_W'(NUM_LEVELS - 1)) ? cur_lvl : cur_lvl + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Apply unlink, append, rotation and pick in order, then tick and status, on the next-state copies
  always_comb begin
    head_nxt      = head_r;
    nonempty_nxt  = nonempty_r;
    next_nxt      = next_r;
    prev_nxt      = prev_r;
    tlevel_nxt    = tlevel_r;
    slices_nxt    = slices_r;
    queued_nxt    = queued_r;
    cur_task_nxt  = cur_task_r;
    cur_valid_nxt = cur_valid_r;
    status        = mlfq_pkg::STATUS_OK;
    switched      = 1'b0;
    found         = 1'b0;
    pick          = '0;
    deq_lvl       = tlevel_r[deq_task];
    deq_n         = next_r[deq_task];
    deq_p         = prev_r[deq_task];
    enq_h         = '0;
    enq_tail      = '0;
    quantum       = Q_W'(base_quantum_r) << enq_lvl;

    // unlink a task from its ring
    if (do_deq) begin
      if (head_nxt[deq_lvl] == deq_task) begin
        if (deq_n == deq_task) begin
          nonempty_nxt[deq_lvl] = 1'b0;
        end else begin
          head_nxt[deq_lvl] = deq_n;
        end
      end
      prev_nxt[deq_n]      = deq_p;
      next_nxt[deq_p]      = deq_n;
      queued_nxt[deq_task] = 1'b0;
      slices_nxt[deq_task] = '0;
    end

    // append a task at the tail of its level and grant its quantum
    if (do_enq) begin
      tlevel_nxt[enq_task] = enq_lvl;
      if (!nonempty_nxt[enq_lvl]) begin
        next_nxt[enq_task]    = enq_task;
        prev_nxt[enq_task]    = enq_task;
        head_nxt[enq_lvl]     = enq_task;
        nonempty_nxt[enq_lvl] = 1'b1;
      end else begin
        enq_h              = head_nxt[enq_lvl];
        enq_tail           = prev_nxt[enq_h];
        next_nxt[enq_task] = enq_h;
        prev_nxt[enq_task] = enq_tail;
        prev_nxt[enq_h]    = enq_task;
        next_nxt[enq_tail] = enq_task;
      end
      queued_nxt[enq_task] = 1'b1;
      slices_nxt[enq_task] = (quantum > Q_W'(mlfq_pkg::SLICE_MAX)) ?
                             mlfq_pkg::SLICE_MAX : quantum[mlfq_pkg::SLICE_W-1:0];
    end

    // move the level head past a running task with slices left
    if (do_rotate) begin
      head_nxt[cur_lvl] = next_r[cur_task_r];
    end

    // find the head of the highest non-empty level
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_nxt[i]) begin
        found = 1'b1;
        pick  = head_nxt[i];
      end
    end

    case (op_r)
      mlfq_pkg::OP_ADD, mlfq_pkg::OP_REMOVE: begin
        if (!do_enq && !do_deq) begin
          status = mlfq_pkg::STATUS_BAD;
        end
      end
      mlfq_pkg::OP_TICK: begin
        if (!cur_valid_r) begin
          status = mlfq_pkg::STATUS_IDLE;
        end else if (slices_r[cur_task_r] != '0) begin
          slices_nxt[cur_task_r] = slices_r[cur_task_r] - 1'b1;
        end
      end
      mlfq_pkg::OP_SCHEDULE: begin
        if (!found) begin
          cur_valid_nxt = 1'b0;
          cur_task_nxt  = '0;
          status        = mlfq_pkg::STATUS_IDLE;
        end else begin
          switched      = !(cur_valid_r && cur_task_r == pick);
          cur_task_nxt  = pick;
          cur_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_quantum_r <= mlfq_pkg::QUANTUM_RESET;
    end else if (cfg_wr_en) begin
      base_quantum_r <= cfg_wr_data;
    end
  end

  // Request register: load on transfer, drop when passed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      op_r    <= mlfq_pkg::op_t'(in_chan.operation);
      id_r    <= in_chan.task_id;
      lvl_r   <= in_chan.level;
      ready_r <= in_chan.current_ready;
    end
  end

  // Result register: load on commit, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_task_r     <= cur_valid_nxt ? mlfq_pkg::TASK_ID_W'(cur_task_nxt) : '0;
      out_switched_r <= switched;
      out_status_r   <= status;
    end
  end

  // Scheduler state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i]     <= '0;
        nonempty_r[i] <= 1'b0;
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
        tlevel_r[i] <= '0;
        slices_r[i] <= '0;
        queued_r[i] <= 1'b0;
      end
      cur_task_r  <= '0;
      cur_valid_r <= 1'b0;
    end else if (commit) begin
      head_r      <= head_nxt;
      nonempty_r  <= nonempty_nxt;
      tlevel_r    <= tlevel_nxt;
      slices_r    <= slices_nxt;
      queued_r    <= queued_nxt;
      cur_task_r  <= cur_task_nxt;
      cur_valid_r <= cur_valid_nxt;
    end
  end

  // Ring links, written only when a task is queued or unlinked
  always_ff @(posedge clk) begin
    if (commit) begin
      next_r <= next_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

/* sv/mlfq_checker.sv */
// Port-level checks on the scheduler result channel, bound to the scheduler module.
module mlfq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mlfq_pkg::TASK_ID_W-1:0]   out_running_task,
  input logic                             out_switched,
  input logic [mlfq_pkg::STATUS_W-1:0]    out_status
);

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_running_task) &&
                                $stable(out_switched) && $stable(out_status))
    else $error("result changed while stalled");

  // No runnable task reports task zero and no switch
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mlfq_pkg::STATUS_IDLE |->
      out_running_task == '0 && !out_switched)
    else $error("running task or switch reported with no runnable task");

  // A switch only comes with an ok status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_status == mlfq_pkg::STATUS_OK)
    else $error("switch with error status");

  // Reset empties the result channel
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mlfq_task_scheduler mlfq_checker u_mlfq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_running_task (out_chan.running_task),
  .out_switched     (out_chan.switched),
  .out_status       (out_chan.status)
);

/* tb/tb_top.sv */
// Self-checking regression of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_LEVELS  = 4;
  localparam int NUM_TASKS   = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [mlfq_pkg::TASK_ID_W-1:0] running_task;
    logic                           switched;
    mlfq_pkg::status_t              status;
  } sched_outcome_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [mlfq_pkg::QUANTUM_W-1:0] cfg_wr_data;

  mlfq_in_if  in_if ();
  mlfq_out_if out_if ();

  mlfq_task_scheduler #(
    .NUM_LEVELS(NUM_LEVELS),
    .NUM_TASKS (NUM_TASKS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the scheduler tables
  logic [mlfq_pkg::QUANTUM_W-1:0] quantum;
  logic [mlfq_pkg::TASK_ID_W-1:0] lvl_head  [NUM_LEVELS];
  logic                           lvl_busy  [NUM_LEVELS];
  logic [mlfq_pkg::TASK_ID_W-1:0] nxt_task  [NUM_TASKS];
  logic [mlfq_pkg::TASK_ID_W-1:0] prv_task  [NUM_TASKS];
  logic [mlfq_pkg::LEVEL_W-1:0]   task_lvl  [NUM_TASKS];
  logic [mlfq_pkg::SLICE_W-1:0]   slices    [NUM_TASKS];
  logic                           queued    [NUM_TASKS];
  logic [mlfq_pkg::TASK_ID_W-1:0] cur_task;
  logic                           cur_valid;

  sched_outcome_t outcome_fifo[$];
  int unsigned    mismatch_count = 0;
  int unsigned    result_count = 0;
  bit             steady_flow = 1'b0;

  // Append a task at the tail of its level and grant its quantum
  function automatic void link_task(logic [mlfq_pkg::TASK_ID_W-1:0] t,
                                    logic [mlfq_pkg::LEVEL_W-1:0] lv);
    logic [mlfq_pkg::TASK_ID_W-1:0] h;
    logic [mlfq_pkg::TASK_ID_W-1:0] tl;
    int unsigned q;
    task_lvl[t] = lv;
    if (!lvl_busy[lv]) begin
      nxt_task[t] = t;
      prv_task[t] = t;
      lvl_head[lv] = t;
      lvl_busy[lv] = 1'b1;
    end else begin
      h = lvl_head[lv];
      tl = prv_task[h];
      nxt_task[t] = h;
      prv_task[t] = tl;
      prv_task[h] = t;
      nxt_task[tl] = t;
    end
    queued[t] = 1'b1;
    q = 32'(quantum);
    q = q << lv;
    slices[t] = (q > mlfq_pkg::SLICE_MAX) ? mlfq_pkg::SLICE_MAX : q[mlfq_pkg::SLICE_W-1:0];
  endfunction

  // Unlink a task from its level and clear its slices
  function automatic void unlink_task(logic [mlfq_pkg::TASK_ID_W-1:0] t);
    logic [mlfq_pkg::LEVEL_W-1:0]   lv;
    logic [mlfq_pkg::TASK_ID_W-1:0] n;
    logic [mlfq_pkg::TASK_ID_W-1:0] p;
    lv = task_lvl[t];
    n = nxt_task[t];
    p = prv_task[t];
    if (lvl_head[lv] == t) begin
      if (n == t) lvl_busy[lv] = 1'b0;
      else lvl_head[lv] = n;
    end
    prv_task[n] = p;
    nxt_task[p] = n;
    queued[t] = 1'b0;
    slices[t] = '0;
  endfunction

  // Advance the shadow tables by one request and return its outcome
  function automatic sched_outcome_t apply_request(mlfq_pkg::op_t op,
                                                   logic [mlfq_pkg::TASK_ID_W-1:0] id,
                                                   logic [mlfq_pkg::LEVEL_W-1:0] lv,
                                                   logic rdy);
    sched_outcome_t r;
    logic [mlfq_pkg::LEVEL_W-1:0]   cl;
    logic [mlfq_pkg::LEVEL_W-1:0]   nl;
    logic [mlfq_pkg::TASK_ID_W-1:0] pick;
    logic [mlfq_pkg::TASK_ID_W-1:0] c;
    bit found;
    int i;
    r.switched = 1'b0;
    r.status = mlfq_pkg::STATUS_OK;
    case (op)
      mlfq_pkg::OP_ADD: begin
        if (queued[id]) r.status = mlfq_pkg::STATUS_BAD;
        else link_task(id, lv);
      end
      mlfq_pkg::OP_REMOVE: begin
        if (!queued[id]) r.status = mlfq_pkg::STATUS_BAD;
        else unlink_task(id);
      end
      mlfq_pkg::OP_TICK: begin
        if (!cur_valid) r.status = mlfq_pkg::STATUS_IDLE;
        else if (slices[cur_task] != '0) slices[cur_task] = slices[cur_task] - 1'b1;
      end
      default: begin
        // Rotate or demote the running task, then pick the top non-empty level
        if (cur_valid && rdy && queued[cur_task]) begin
          c = cur_task;
          cl = task_lvl[c];
          if (slices[c] != '0) begin
            lvl_head[cl] = nxt_task[c];
          end else begin
            nl = (cl == mlfq_pkg::LEVEL_W'(NUM_LEVELS - 1)) ? cl : cl + 1'b1;
            unlink_task(c);
            link_task(c, nl);
          end
        end
        found = 1'b0;
        pick = '0;
        for (i = NUM_LEVELS - 1; i >= 0; i--) begin
          if (lvl_busy[i]) begin
            pick = lvl_head[i];
            found = 1'b1;
          end
        end
        if (!found) begin
          cur_valid = 1'b0;
          cur_task = '0;
          r.status = mlfq_pkg::STATUS_IDLE;
        end else begin
          if (!(cur_valid && cur_task == pick)) r.switched = 1'b1;
          cur_task = pick;
          cur_valid = 1'b1;
        end
      end
    endcase
    r.running_task = cur_valid ? cur_task : '0;
    return r;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  // Draw a task id, preferring one whose queued state matches the request
  function automatic logic [mlfq_pkg::TASK_ID_W-1:0] pick_task(bit want_queued,
                                                               int unsigned span);
    logic [mlfq_pkg::TASK_ID_W-1:0] t;
    int k;
    t = mlfq_pkg::TASK_ID_W'($urandom_range(0, span - 1));
    for (k = 0; k < 8; k++) begin
      if (queued[t] == want_queued) return t;
      t = mlfq_pkg::TASK_ID_W'($urandom_range(0, span - 1));
    end
    return t;
  endfunction

  // Transfer one request after a random gap and record its outcome
  task automatic send_request(mlfq_pkg::op_t op, logic [mlfq_pkg::TASK_ID_W-1:0] id,
                              logic [mlfq_pkg::LEVEL_W-1:0] lv, logic rdy);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= op;
    in_if.task_id       <= id;
    in_if.level         <= lv;
    in_if.current_ready <= rdy;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    outcome_fifo.push_back(apply_request(op, id, lv, rdy));
  endtask

  // Hold the request channel idle until every outcome has been checked
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (outcome_fifo.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_quantum(logic [mlfq_pkg::QUANTUM_W-1:0] q);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    quantum = q;
  endtask

  // Empty scheduler: schedule, tick and remove all have nothing to act on
  task automatic test_empty_scheduler();
    send_request(mlfq_pkg::OP_SCHEDULE, 5'd0, 2'd0, 1'b1);
    send_request(mlfq_pkg::OP_TICK, 5'd0, 2'd0, 1'b1);
    send_request(mlfq_pkg::OP_REMOVE, 5'd5, 2'd0, 1'b0);
  endtask

  // Round robin, duplicate add, not-ready schedule and demotion
  task automatic test_round_robin();
    wait_drained();
    set_quantum(8'd1);
    send_request(mlfq_pkg::OP_ADD, 5'd0, 2'd0, 1'b0);
    send_request(mlfq_pkg::OP_ADD, 5'd31, 2'd0, 1'b1);
    send_request(mlfq_pkg::OP_ADD, 5'd31, 2'd2, 1'b0);
    send_request(mlfq_pkg::OP_ADD, 5'd7, 2'd3, 1'b1);
    send_request(mlfq_pkg::OP_SCHEDULE, 5'd0, 2'd0, 1'b1);
    send_request(mlfq_pkg::OP_TICK, 5'd0, 2'd0, 1'b0);
    send_request(mlfq_pkg::OP_SCHEDULE, 5'd0, 2'd0, 1'b1);
    send_request(mlfq_pkg::OP_SCHEDULE, 5'd0, 2'd0, 1'b0);
    send_request(mlfq_pkg::OP_TICK, 5'd0, 2'd0, 1'b1);
    send_request(mlfq_pkg::OP_TICK, 5'd0, 2'd0, 1'b1);
    send_request(mlfq_pkg::OP_SCHEDULE, 5'd0, 2'd0, 1'b1);
    send_request(mlfq_pkg::OP_SCHEDULE, 5'd0, 2'd0, 1'b1);
  endtask

  // Remove the running task, then empty every level and schedule again
  task automatic test_remove_running();
    int t;
    send_request(mlfq_pkg::OP_REMOVE, cur_task, 2'd0, 1'b0);
    send_request(mlfq_pkg::OP_SCHEDULE, 5'd0, 2'd0, 1'b1);
    for (t = 0; t < NUM_TASKS; t++) begin
      if (queued[t]) send_request(mlfq_pkg::OP_REMOVE, t[mlfq_pkg::TASK_ID_W-1:0], 2'd1, 1'b1);
    end
    send_request(mlfq_pkg::OP_SCHEDULE, 5'd0, 2'd0, 1'b1);
    send_request(mlfq_pkg::OP_TICK, 5'd0, 2'd0, 1'b0);
  endtask

  // Weighted random traffic under one quantum setting
  task automatic test_random_traffic(logic [mlfq_pkg::QUANTUM_W-1:0] q, int unsigned span,
                                     int unsigned n);
    int unsigned k;
    int unsigned r;
    mlfq_pkg::op_t op;
    logic [mlfq_pkg::TASK_ID_W-1:0] id;
    logic [mlfq_pkg::LEVEL_W-1:0]   lv;
    logic                           rdy;
    wait_drained();
    set_quantum(q);
    for (k = 0; k < n; k++) begin
      steady_flow = (k >= n / 4) && (k < n / 4 + 30);
      if (k == n / 2) wait_drained();
      r   = $urandom_range(0, 99);
      id  = mlfq_pkg::TASK_ID_W'($urandom_range(0, span - 1));
      lv  = mlfq_pkg::LEVEL_W'($urandom_range(0, 3));
      rdy = ($urandom_range(0, 3) != 0);
      if (r < 30) begin
        op = mlfq_pkg::OP_ADD;
        id = pick_task(1'b0, span);
      end else if (r < 42) begin
        op = mlfq_pkg::OP_REMOVE;
        if (r < 35 && cur_valid && queued[cur_task]) id = cur_task;
        else id = pick_task(1'b1, span);
      end else if (r < 70) begin
        op = mlfq_pkg::OP_SCHEDULE;
      end else begin
        op = mlfq_pkg::OP_TICK;
      end
      send_request(op, id, lv, rdy);
    end
    steady_flow = 1'b0;
  endtask

  // Check each result transfer against the oldest recorded outcome
  always @(posedge clk) begin : result_check
    sched_outcome_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      result_count++;
      if (outcome_fifo.size() == 0) begin
        note_mismatch($sformatf("result %0d with no outstanding request", result_count));
      end else begin
        want = outcome_fifo.pop_front();
        if (out_if.running_task !== want.running_task || out_if.switched !== want.switched ||
            out_if.status !== want.status)
          note_mismatch($sformatf(
            "result %0d running_task %0d/%0d switched %0d/%0d status %0d/%0d (exp/act)",
            result_count, want.running_task, out_if.running_task, want.switched,
            out_if.switched, want.status, out_if.status));
      end
    end
  end

  // Random backpressure on the result channel
  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  // Stop a hung run
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_seq
    int t;
    int unsigned waited;
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    in_if.valid         <= 1'b0;
    in_if.operation     <= mlfq_pkg::OP_ADD;
    in_if.task_id       <= '0;
    in_if.level         <= '0;
    in_if.current_ready <= 1'b0;

    // Shadow state after reset
    quantum = mlfq_pkg::QUANTUM_RESET;
    for (t = 0; t < NUM_LEVELS; t++) begin
      lvl_head[t] = '0;
      lvl_busy[t] = 1'b0;
    end
    for (t = 0; t < NUM_TASKS; t++) begin
      nxt_task[t] = '0;
      prv_task[t] = '0;
      task_lvl[t] = '0;
      slices[t]   = '0;
      queued[t]   = 1'b0;
    end
    cur_task = '0;
    cur_valid = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_scheduler();
    test_round_robin();
    test_remove_running();
    test_random_traffic(8'd1, 8, 110);
    test_random_traffic(8'd255, 32, 110);
    test_random_traffic(8'($urandom_range(1, 4)), 12, 110);
    test_random_traffic(8'($urandom_range(1, 255)), 32, 110);

    // Drain outstanding results with a bound, then settle
    in_if.valid <= 1'b0;
    waited = 0;
    while (outcome_fifo.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
    if (outcome_fifo.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", outcome_fifo.size()));

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* mlfq_task_scheduler.f */
sv/mlfq_pkg.sv
sv/mlfq_if.sv
sv/mlfq_task_scheduler.sv
sv/mlfq_checker.sv
tb/tb_top.sv
